[sv/sthp_pkg.sv]
// Shared constants and types for the stereo tight highpass unit.
// No dependencies; imported by stereo_tight_highpass_unit.
package sthp_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int TDATA_BITS    = 2 * SAMPLE_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 18;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_CUTOFF    = 2'd0;
  localparam cfg_idx_t REG_TIGHTNESS = 2'd1;
  localparam cfg_idx_t REG_MIX       = 2'd2;
  localparam cfg_idx_t REG_RATE      = 2'd3;

  // reset values
  localparam logic [15:0] CUTOFF_RST    = 16'd0;
  localparam logic [15:0] TIGHTNESS_RST = 16'd32768;
  localparam logic [16:0] MIX_RST       = 17'd65536;
  localparam logic [17:0] RATE_RST      = 18'd65536;

  // 1.0 in Q16, and ceil(2^17/3) for exact n/3 with n < 2^17
  localparam int unsigned Q16_ONE    = 65536;
  localparam int unsigned DIV3_RECIP = 43691;

endpackage

[sv/stereo_tight_highpass_unit.sv]
// Stereo tight highpass: one-pole highpass per channel with level-dependent
// coefficient, ping-pong lowpass states and wet/dry mix. Uses sthp_pkg.
//
// One stereo frame in, one frame out. All arithmetic runs through a single
// 34x18 unsigned multiplier under a step sequencer: six multiplies form the
// coefficient and the tightness offset, then five per channel (offset, gain,
// lowpass update, wet term, dry term). Each multiply passes through an operand
// load and a product register, and s_axis_tready is high only between frames.
// The output register holds the previous result, so a new frame is taken while
// that result still waits for m_axis_tready.
module stereo_tight_highpass_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // stream in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sthp_pkg::TDATA_BITS-1:0]  s_axis_tdata,  // right_sample (high), left_sample (low)
  // stream out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sthp_pkg::TDATA_BITS-1:0]  m_axis_tdata,  // right_out (high), left_out (low)
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [sthp_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [sthp_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import sthp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // each step uses the previous product and loads the next operands (square has no product to use, sum loads none)
  localparam logic [3:0] STEP_SQUARE  = 4'd0;
  localparam logic [3:0] STEP_CUBE    = 4'd1;
  localparam logic [3:0] STEP_RATE    = 4'd2;
  localparam logic [3:0] STEP_DIV3    = 4'd3;
  localparam logic [3:0] STEP_TSQ     = 4'd4;
  localparam logic [3:0] STEP_COEF    = 4'd5;
  localparam logic [3:0] STEP_OFFSET  = 4'd6;
  localparam logic [3:0] STEP_GAIN    = 4'd7;
  localparam logic [3:0] STEP_LOWPASS = 4'd8;
  localparam logic [3:0] STEP_WET     = 4'd9;
  localparam logic [3:0] STEP_DRY     = 4'd10;
  localparam logic [3:0] STEP_SUM     = 4'd11;

  logic [1:0]  state_q, state_d;
  logic [3:0]  step_q;
  logic        wait_q;
  logic        ch_q;
  logic        use_even_q;
  logic        out_valid_q;

  logic [15:0] cutoff_q;
  logic [15:0] tight_q;
  logic [16:0] mix_q;
  logic [17:0] rate_q;

  logic [31:0] lp_le_q, lp_lo_q, lp_re_q, lp_ro_q;

  logic [SAMPLE_BITS-1:0] xl_q, xr_q, yl_q, yr_q, out_l_q, out_r_q;
  logic [33:0] op_a_q;
  logic [17:0] op_b_q;
  logic [51:0] prod_q;
  logic [33:0] acc_q;
  logic [15:0] td_mag_q;
  logic        tdp_q;
  logic [16:0] coef_q;
  logic [32:0] d_q;
  logic [34:0] y_q;

  logic        in_xfer, out_load, run_step;

  logic [SAMPLE_BITS-1:0] x_cur, x_mag;
  logic [16:0] m16;
  logic [31:0] xs, xs_mag, st_cur, st_new;
  logic [32:0] d_cur, d_mag, r_lp;
  logic [17:0] tq;
  logic        tq_pos;
  logic [16:0] tq_mag, div_n;
  logic [19:0] coef_raw;
  logic [16:0] coef_sat;
  logic [16:0] q_off, off_a, off_sat;
  logic [18:0] off_raw;
  logic [16:0] wet, dry;
  logic [32:0] t_wet;
  logic [31:0] t_dry;
  logic [34:0] term_dry, y_sum;
  logic [26:0] y_sh;
  logic [SAMPLE_BITS-1:0] y_sat;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign run_step      = (state_q == ST_RUN) && !wait_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_r_q, out_l_q};

  always_comb begin
    // current channel sample and its lowpass state
    x_cur  = ch_q ? xr_q : xl_q;
    x_mag  = x_cur[SAMPLE_BITS-1] ? (~x_cur + 1'b1) : x_cur;
    m16    = x_mag[23:7];
    xs     = {x_cur, 8'd0};
    xs_mag = {x_mag, 8'd0};
    case ({ch_q, use_even_q})
      2'b01:   st_cur = lp_le_q;
      2'b00:   st_cur = lp_lo_q;
      2'b11:   st_cur = lp_re_q;
      default: st_cur = lp_ro_q;
    endcase
    d_cur = {xs[31], xs} - {st_cur[31], st_cur};
    d_mag = d_q[32] ? (~d_q + 1'b1) : d_q;

    // tight = 2*knob - 1 in signed Q16
    tq     = {1'b0, tight_q, 1'b0} - 18'(Q16_ONE);
    tq_pos = !tq[17] && (tq != 18'd0);
    tq_mag = tq[17] ? 17'(~tq + 1'b1) : tq[16:0];
    div_n  = tq_pos ? {tq[15:0], 1'b0} : tq_mag;

    coef_raw = prod_q[51:32];
    coef_sat = (coef_raw > 20'(Q16_ONE)) ? 17'(Q16_ONE) : coef_raw[16:0];

    off_a   = tdp_q ? m16 : (17'(Q16_ONE) - m16);
    q_off   = prod_q[32:16];
    off_raw = tdp_q ? (19'(Q16_ONE) - 19'(td_mag_q) + 19'(q_off))
                    : (19'(Q16_ONE) - 19'(td_mag_q) - 19'(q_off));
    if (off_raw[18]) begin
      off_sat = 17'd0;
    end else if (off_raw > 19'(Q16_ONE)) begin
      off_sat = 17'(Q16_ONE);
    end else begin
      off_sat = off_raw[16:0];
    end

    // lowpass step magnitude never exceeds |xs - lp|
    r_lp   = prod_q[48:16];
    st_new = d_q[32] ? (st_cur - r_lp[31:0]) : (st_cur + r_lp[31:0]);

    wet = (mix_q > 17'(Q16_ONE)) ? 17'(Q16_ONE) : mix_q;
    dry = 17'(Q16_ONE) - wet;

    t_wet    = prod_q[48:16];
    t_dry    = prod_q[47:16];
    term_dry = xs[31] ? (~35'(t_dry) + 1'b1) : 35'(t_dry);
    y_sum    = y_q + term_dry;
    y_sh     = y_sum[34:8];
    if (y_sh[26:23] == {4{y_sh[23]}}) begin
      y_sat = y_sh[23:0];
    end else begin
      y_sat = y_sh[26] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (run_step && step_q == STEP_SUM && ch_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_SQUARE;
      wait_q      <= 1'b0;
      ch_q        <= 1'b0;
      use_even_q  <= 1'b1;
      out_valid_q <= 1'b0;
      cutoff_q    <= CUTOFF_RST;
      tight_q     <= TIGHTNESS_RST;
      mix_q       <= MIX_RST;
      rate_q      <= RATE_RST;
      lp_le_q     <= '0;
      lp_lo_q     <= '0;
      lp_re_q     <= '0;
      lp_ro_q     <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CUTOFF:    cutoff_q <= cfg_data_i[15:0];
          REG_TIGHTNESS: tight_q  <= cfg_data_i[15:0];
          REG_MIX:       mix_q    <= cfg_data_i[16:0];
          REG_RATE:      rate_q   <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (in_xfer) begin
        step_q <= STEP_SQUARE;
        wait_q <= 1'b0;
        ch_q   <= 1'b0;
      end else if (state_q == ST_RUN) begin
        if (wait_q) begin
          wait_q <= 1'b0;
        end else begin
          // nothing loaded at the sum step, so no product to wait for
          wait_q <= (step_q != STEP_SUM);
          if (step_q == STEP_SUM && !ch_q) begin
            ch_q   <= 1'b1;
            step_q <= STEP_OFFSET;
          end else begin
            step_q <= step_q + 4'd1;
          end
          if (step_q == STEP_WET) begin
            case ({ch_q, use_even_q})
              2'b01:   lp_le_q <= st_new;
              2'b00:   lp_lo_q <= st_new;
              2'b11:   lp_re_q <= st_new;
              default: lp_ro_q <= st_new;
            endcase
          end
          if (step_q == STEP_SUM && ch_q) begin
            use_even_q <= !use_even_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 52'(op_a_q) * 52'(op_b_q);

    if (in_xfer) begin
      xl_q <= s_axis_tdata[SAMPLE_BITS-1:0];
      xr_q <= s_axis_tdata[TDATA_BITS-1:SAMPLE_BITS];
    end

    if (out_load) begin
      out_l_q <= yl_q;
      out_r_q <= yr_q;
    end

    if (run_step) begin
      case (step_q)
        STEP_SQUARE: begin
          op_a_q <= 34'(cutoff_q);
          op_b_q <= 18'(cutoff_q);
        end
        STEP_CUBE: begin
          op_a_q <= 34'(prod_q[31:0]);
          op_b_q <= 18'(cutoff_q);
        end
        STEP_RATE: begin
          op_a_q <= 34'(prod_q[47:16]);
          op_b_q <= rate_q;
        end
        STEP_DIV3: begin
          acc_q  <= prod_q[49:16];
          op_a_q <= 34'(div_n);
          op_b_q <= 18'(DIV3_RECIP);
        end
        STEP_TSQ: begin
          td_mag_q <= prod_q[32:17];
          tdp_q    <= tq_pos;
          op_a_q   <= 34'(tq_mag);
          op_b_q   <= 18'(tq_mag);
        end
        STEP_COEF: begin
          op_a_q <= acc_q;
          op_b_q <= 18'(Q16_ONE) + 18'(prod_q[32:16]);
        end
        STEP_OFFSET: begin
          // second channel enters here with an unrelated product
          if (!ch_q) coef_q <= coef_sat;
          d_q    <= d_cur;
          op_a_q <= 34'(off_a);
          op_b_q <= 18'(td_mag_q);
        end
        STEP_GAIN: begin
          op_a_q <= 34'(off_sat);
          op_b_q <= 18'(coef_q);
        end
        STEP_LOWPASS: begin
          op_a_q <= 34'(d_mag);
          op_b_q <= 18'(prod_q[32:16]);
        end
        STEP_WET: begin
          // |xs - new lp| = |d| - r, sign follows d
          op_a_q <= 34'(d_mag - r_lp);
          op_b_q <= 18'(wet);
        end
        STEP_DRY: begin
          y_q    <= d_q[32] ? (~35'(t_wet) + 1'b1) : 35'(t_wet);
          op_a_q <= 34'(xs_mag);
          op_b_q <= 18'(dry);
        end
        STEP_SUM: begin
          if (ch_q) begin
            yr_q <= y_sat;
          end else begin
            yl_q <= y_sat;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
